@@ rtl/video_unit_register_port_top_assert.svh @@
// Assertion macros used by the checker file.
`ifndef VIDEO_UNIT_REGISTER_PORT_TOP_ASSERT_SVH
`define VIDEO_UNIT_REGISTER_PORT_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define VURP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define VURP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/vurp_pkg.sv @@
`default_nettype none

package vurp_pkg;

    localparam int DATA_W   = 8;
    localparam int BUS_AW   = 14;
    localparam int VADDR_W  = 15;
    localparam int NT_BYTES = 1024;
    localparam int NT_AW    = $clog2(2 * NT_BYTES);
    localparam int PAL_DEPTH = 32;
    localparam int PAL_AW   = $clog2(PAL_DEPTH);

    // Transaction kinds
    localparam logic [2:0] KIND_READ    = 3'd0;
    localparam logic [2:0] KIND_PEEK    = 3'd1;
    localparam logic [2:0] KIND_WRITE   = 3'd2;
    localparam logic [2:0] KIND_VB_SET  = 3'd3;
    localparam logic [2:0] KIND_VB_CLR  = 3'd4;

    // Register indexes
    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_MASK     = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_OAM_ADDR = 3'd3;
    localparam logic [2:0] REG_OAM_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    // Bus map constants
    localparam logic [BUS_AW-1:0] PAL_BASE = 14'h3F00;
    localparam logic [DATA_W-1:0] PAL_MASK_GREY = 8'h30;
    localparam logic [DATA_W-1:0] PAL_MASK_FULL = 8'h3F;
    localparam logic [VADDR_W-1:0] STEP_ROW = 15'd32;
    localparam logic [VADDR_W-1:0] STEP_COL = 15'd1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_READ
    } t_state;

    typedef enum logic [1:0] {
        SP_PATTERN,
        SP_NAMETABLE,
        SP_PALETTE
    } t_space;

    // Decoded bus target for the current address
    typedef struct packed {
        t_space            space;
        logic [NT_AW-1:0]  nt_idx;
        logic [PAL_AW-1:0] pal_idx;
    } t_bus_sel;

endpackage

`default_nettype wire

@@ rtl/vurp_ram.sv @@
`default_nettype none

module vurp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Single port, registered read; read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/vurp_bus_map.sv @@
`default_nettype none

module vurp_bus_map #(
    parameter int PATTERN_BYTES = 8192,
    localparam int PAT_AW = $clog2(PATTERN_BYTES)
) (
    input  wire logic [vurp_pkg::BUS_AW-1:0] i_addr,
    input  wire logic                        i_mirror,
    output vurp_pkg::t_bus_sel               o_sel,
    output logic      [PAT_AW-1:0]           o_pat_idx
);

    logic [vurp_pkg::BUS_AW-1:0] w_pat_full;
    logic [vurp_pkg::BUS_AW-1:0] w_pat_red;
    logic                        w_page;

    // Pattern space modulo the RAM size; offset is below twice the size
    always_comb begin
        w_pat_full = {1'b0, i_addr[12:0]};
        if (w_pat_full >= vurp_pkg::BUS_AW'(PATTERN_BYTES)) begin
            w_pat_red = w_pat_full - vurp_pkg::BUS_AW'(PATTERN_BYTES);
        end else begin
            w_pat_red = w_pat_full;
        end
    end

    assign o_pat_idx = w_pat_red[PAT_AW-1:0];

    // Region decode, name table page and palette aliasing
    always_comb begin
        w_page = i_mirror ? i_addr[11] : i_addr[10];
        o_sel.nt_idx = {w_page, i_addr[9:0]};
        if (i_addr[4] && (i_addr[1:0] == 2'b00)) begin
            o_sel.pal_idx = {1'b0, i_addr[3:0]};
        end else begin
            o_sel.pal_idx = i_addr[4:0];
        end
        if (!i_addr[13]) begin
            o_sel.space = vurp_pkg::SP_PATTERN;
        end else if (i_addr >= vurp_pkg::PAL_BASE) begin
            o_sel.space = vurp_pkg::SP_PALETTE;
        end else begin
            o_sel.space = vurp_pkg::SP_NAMETABLE;
        end
    end

endmodule

`default_nettype wire

@@ rtl/video_unit_register_port_top.sv @@
`default_nettype none

// CPU register window of a tile video unit: eight registers, with video memory
// (pattern, name table and palette RAM) reached through the data register.
// Every transaction gives exactly one result. A data register read waits in
// ST_READ, with input held off, for the video RAMs' registered read; the
// others give their result in the next cycle. A result register sits on the
// output, so a new transaction is taken in the cycle its predecessor's
// result is consumed. The RAMs need no clearing after reset. The user keeps
// mirror_mode written through i_cfg_we/i_cfg_wdata only while idle, unenforced.

module video_unit_register_port_top #(
    parameter int PATTERN_BYTES = 8192
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_wdata,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [2:0] i_kind,
    input  wire logic [2:0] i_reg_index,
    input  wire logic [7:0] i_write_data,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_read_data,
    output logic            o_nmi_raise
);

    localparam int PAT_AW = $clog2(PATTERN_BYTES);
    localparam int DW = vurp_pkg::DATA_W;

    vurp_pkg::t_state  r_state, n_state;
    logic              r_out_valid, n_out_valid;
    logic [DW-1:0]     r_out_data, n_out_data;
    logic              r_out_nmi, n_out_nmi;
    logic [DW-1:0]     r_ctrl, n_ctrl;
    logic [DW-1:0]     r_mask, n_mask;
    logic              r_vblank, n_vblank;
    logic              r_toggle, n_toggle;
    logic [2:0]        r_fine, n_fine;
    logic [vurp_pkg::VADDR_W-1:0] r_temp, n_temp;
    logic [vurp_pkg::VADDR_W-1:0] r_cur, n_cur;
    logic [DW-1:0]     r_rbuf, n_rbuf;
    logic              r_mirror;
    vurp_pkg::t_space  r_pend_space, n_pend_space;

    logic              w_out_free;
    logic              w_accept;
    logic [vurp_pkg::VADDR_W-1:0] w_cur_step;
    logic [DW-1:0]     w_rd_raw;
    logic [DW-1:0]     w_rd_val;
    vurp_pkg::t_bus_sel w_sel;
    logic [PAT_AW-1:0] w_pat_idx;
    logic              w_mem_we, w_mem_re;
    logic              w_pat_we, w_pat_re, w_nt_we, w_nt_re, w_pal_we, w_pal_re;
    logic [DW-1:0]     w_pat_q, w_nt_q, w_pal_q;

    // Handshake
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != vurp_pkg::ST_IDLE) || !w_out_free;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;
    assign o_nmi_raise = r_out_nmi;

    // Bus address decode of the current address
    vurp_bus_map #(
        .PATTERN_BYTES(PATTERN_BYTES)
    ) u_map (
        .i_addr    (r_cur[vurp_pkg::BUS_AW-1:0]),
        .i_mirror  (r_mirror),
        .o_sel     (w_sel),
        .o_pat_idx (w_pat_idx)
    );

    // Memory strobes for data register transactions
    always_comb begin
        w_mem_we = w_accept && (i_kind == vurp_pkg::KIND_WRITE)
                   && (i_reg_index == vurp_pkg::REG_DATA);
        w_mem_re = w_accept && (i_kind == vurp_pkg::KIND_READ)
                   && (i_reg_index == vurp_pkg::REG_DATA);
        w_pat_we = w_mem_we && (w_sel.space == vurp_pkg::SP_PATTERN);
        w_pat_re = w_mem_re && (w_sel.space == vurp_pkg::SP_PATTERN);
        w_nt_we  = w_mem_we && (w_sel.space == vurp_pkg::SP_NAMETABLE);
        w_nt_re  = w_mem_re && (w_sel.space == vurp_pkg::SP_NAMETABLE);
        w_pal_we = w_mem_we && (w_sel.space == vurp_pkg::SP_PALETTE);
        w_pal_re = w_mem_re && (w_sel.space == vurp_pkg::SP_PALETTE);
    end

    vurp_ram #(.WIDTH(DW), .DEPTH(PATTERN_BYTES)) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (w_pat_we),
        .i_re    (w_pat_re),
        .i_addr  (w_pat_idx),
        .i_wdata (i_write_data),
        .o_rdata (w_pat_q)
    );

    vurp_ram #(.WIDTH(DW), .DEPTH(2 * vurp_pkg::NT_BYTES)) u_nt_ram (
        .i_clk   (i_clk),
        .i_we    (w_nt_we),
        .i_re    (w_nt_re),
        .i_addr  (w_sel.nt_idx),
        .i_wdata (i_write_data),
        .o_rdata (w_nt_q)
    );

    vurp_ram #(.WIDTH(DW), .DEPTH(vurp_pkg::PAL_DEPTH)) u_pal_ram (
        .i_clk   (i_clk),
        .i_we    (w_pal_we),
        .i_re    (w_pal_re),
        .i_addr  (w_sel.pal_idx),
        .i_wdata (i_write_data),
        .o_rdata (w_pal_q)
    );

    // Read data of the pending access, palette masked by greyscale
    always_comb begin
        unique case (r_pend_space)
            vurp_pkg::SP_PATTERN:   w_rd_raw = w_pat_q;
            vurp_pkg::SP_NAMETABLE: w_rd_raw = w_nt_q;
            vurp_pkg::SP_PALETTE:   w_rd_raw = w_pal_q;
            default:                w_rd_raw = w_pat_q;
        endcase
        if (r_pend_space == vurp_pkg::SP_PALETTE) begin
            w_rd_val = w_rd_raw & (r_mask[0] ? vurp_pkg::PAL_MASK_GREY
                                             : vurp_pkg::PAL_MASK_FULL);
        end else begin
            w_rd_val = w_rd_raw;
        end
    end

    assign w_cur_step = r_cur + (r_ctrl[2] ? vurp_pkg::STEP_ROW : vurp_pkg::STEP_COL);

    // Next state and result
    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_out_nmi    = r_out_nmi;
        n_ctrl       = r_ctrl;
        n_mask       = r_mask;
        n_vblank     = r_vblank;
        n_toggle     = r_toggle;
        n_fine       = r_fine;
        n_temp       = r_temp;
        n_cur        = r_cur;
        n_rbuf       = r_rbuf;
        n_pend_space = r_pend_space;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        // Finish a buffered data read
        if ((r_state == vurp_pkg::ST_READ) && w_out_free) begin
            n_rbuf      = w_rd_val;
            n_out_data  = (r_pend_space == vurp_pkg::SP_PALETTE) ? w_rd_val : r_rbuf;
            n_out_nmi   = 1'b0;
            n_out_valid = 1'b1;
            n_state     = vurp_pkg::ST_IDLE;
        end

        if (w_accept) begin
            n_out_valid = 1'b1;
            n_out_data  = '0;
            n_out_nmi   = 1'b0;
            unique case (i_kind)
                vurp_pkg::KIND_READ: begin
                    if (i_reg_index == vurp_pkg::REG_STATUS) begin
                        n_out_data = {r_vblank, 2'b00, r_rbuf[4:0]};
                        n_vblank   = 1'b0;
                        n_toggle   = 1'b0;
                    end else if (i_reg_index == vurp_pkg::REG_DATA) begin
                        n_out_valid  = 1'b0;
                        n_pend_space = w_sel.space;
                        n_state      = vurp_pkg::ST_READ;
                        n_cur        = w_cur_step;
                    end
                end
                vurp_pkg::KIND_PEEK: begin
                    if (i_reg_index == vurp_pkg::REG_CTRL) begin
                        n_out_data = r_ctrl;
                    end else if (i_reg_index == vurp_pkg::REG_MASK) begin
                        n_out_data = r_mask;
                    end else if (i_reg_index == vurp_pkg::REG_STATUS) begin
                        n_out_data = {r_vblank, 7'b0};
                    end
                end
                vurp_pkg::KIND_WRITE: begin
                    unique case (i_reg_index)
                        vurp_pkg::REG_CTRL: begin
                            n_ctrl         = i_write_data;
                            n_temp[11:10]  = i_write_data[1:0];
                        end
                        vurp_pkg::REG_MASK: begin
                            n_mask = i_write_data;
                        end
                        vurp_pkg::REG_SCROLL: begin
                            if (!r_toggle) begin
                                n_fine       = i_write_data[2:0];
                                n_temp[4:0]  = i_write_data[7:3];
                                n_toggle     = 1'b1;
                            end else begin
                                n_temp[14:12] = i_write_data[2:0];
                                n_temp[9:5]   = i_write_data[7:3];
                                n_toggle      = 1'b0;
                            end
                        end
                        vurp_pkg::REG_ADDR: begin
                            if (!r_toggle) begin
                                n_temp[14]   = 1'b0;
                                n_temp[13:8] = i_write_data[5:0];
                                n_toggle     = 1'b1;
                            end else begin
                                n_temp[7:0] = i_write_data;
                                n_cur       = {r_temp[14:8], i_write_data};
                                n_toggle    = 1'b0;
                            end
                        end
                        vurp_pkg::REG_DATA: begin
                            n_cur = w_cur_step;
                        end
                        default: begin
                        end
                    endcase
                end
                vurp_pkg::KIND_VB_SET: begin
                    n_vblank  = 1'b1;
                    n_out_nmi = r_ctrl[7];
                end
                vurp_pkg::KIND_VB_CLR: begin
                    n_vblank = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Control and register state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vurp_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_ctrl      <= '0;
            r_mask      <= '0;
            r_vblank    <= 1'b0;
            r_toggle    <= 1'b0;
            r_fine      <= '0;
            r_temp      <= '0;
            r_cur       <= '0;
            r_rbuf      <= '0;
            r_mirror    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_ctrl      <= n_ctrl;
            r_mask      <= n_mask;
            r_vblank    <= n_vblank;
            r_toggle    <= n_toggle;
            r_fine      <= n_fine;
            r_temp      <= n_temp;
            r_cur       <= n_cur;
            r_rbuf      <= n_rbuf;
            if (i_cfg_we) begin
                r_mirror <= i_cfg_wdata;
            end
        end
    end

    // Result payload and pending read target
    always_ff @(posedge i_clk) begin
        r_out_data   <= n_out_data;
        r_out_nmi    <= n_out_nmi;
        r_pend_space <= n_pend_space;
    end

endmodule

`default_nettype wire

@@ rtl/vurp_checker.sv @@
`default_nettype none

`include "video_unit_register_port_top_assert.svh"

module vurp_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic [2:0] i_kind,
    input wire logic [2:0] i_reg_index,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_read_data,
    input wire logic       o_nmi_raise
);

    logic w_in_acc;
    logic w_data_read;

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_data_read = (i_kind == vurp_pkg::KIND_READ)
                         && (i_reg_index == vurp_pkg::REG_DATA);

    // A stalled result stays put
    `VURP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_read_data) && $stable(o_nmi_raise), "stalled result changed")

    // NMI only comes with a vblank start, which returns no data
    `VURP_ASSERT_SAME(a_nmi_no_data, i_clk, i_rst_n, o_out_valid && o_nmi_raise, o_read_data == 8'h00, "nmi result carries data")

    // Anything but a data read gives its result in the next cycle
    `VURP_ASSERT_NEXT(a_fast_result, i_clk, i_rst_n, w_in_acc && !w_data_read, o_out_valid, "single-cycle result missing")

    // A data read holds off the next transaction while its RAM read is pending
    `VURP_ASSERT_NEXT(a_read_interlock, i_clk, i_rst_n, w_in_acc && w_data_read, o_in_stall && !o_out_valid, "data read not interlocked")

endmodule

bind video_unit_register_port_top vurp_checker u_vurp_checker (.*);

`default_nettype wire
